>>> hw/rtl/sidm_pkg.sv
// ----------------------------------------------------------------------------
// sidm_pkg
// Types and codes shared by the signed divide / modulo pipeline.
// ----------------------------------------------------------------------------
package sidm_pkg;

  localparam logic [1:0] OP_QUOT = 2'd0;
  localparam logic [1:0] OP_REM  = 2'd1;
  localparam logic [1:0] OP_MOD  = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } sidm_in_t;

  typedef struct packed {
    logic [63:0] result;
    logic        divide_by_zero;
  } sidm_out_t;

  // control that rides along with each word through the pipeline
  typedef struct packed {
    logic       valid;
    logic [1:0] op;
    logic       negx;
    logic       negy;
    logic       dz;
  } sidm_ctl_t;

endpackage

>>> hw/rtl/sidm_front.sv
// ----------------------------------------------------------------------------
// sidm_front
// Input stage: operand signs, magnitudes and zero-divisor detect, registered.
// ----------------------------------------------------------------------------
module sidm_front #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  sidm_pkg::sidm_in_t    in_data,
  output sidm_pkg::sidm_ctl_t   ctl_o,
  output logic [DATA_WIDTH-1:0] ay_o,
  output logic [DATA_WIDTH-1:0] uy_o,
  output logic [DATA_WIDTH-1:0] rem_o,
  output logic [DATA_WIDTH-1:0] qd_o
);
  import sidm_pkg::*;

  logic [DATA_WIDTH-1:0] x;
  logic [DATA_WIDTH-1:0] y;
  sidm_ctl_t             ctl_nxt;
  sidm_ctl_t             ctl_r;
  logic [DATA_WIDTH-1:0] ax_nxt, ay_nxt;
  logic [DATA_WIDTH-1:0] ax_r, ay_r, uy_r;

  assign x = in_data.dividend[DATA_WIDTH-1:0];
  assign y = in_data.divisor[DATA_WIDTH-1:0];

  always_comb begin
    ctl_nxt.valid = in_valid;
    ctl_nxt.op    = in_data.op;
    ctl_nxt.negx  = x[DATA_WIDTH-1];
    ctl_nxt.negy  = y[DATA_WIDTH-1];
    ctl_nxt.dz    = (y == '0);
    // most negative value maps onto 2^(W-1) as unsigned
    ax_nxt = x[DATA_WIDTH-1] ? (~x + 1'b1) : x;
    ay_nxt = y[DATA_WIDTH-1] ? (~y + 1'b1) : y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      uy_r <= y;
    end
  end

  assign ctl_o = ctl_r;
  assign ay_o  = ay_r;
  assign uy_o  = uy_r;
  assign rem_o = '0;
  assign qd_o  = ax_r;

endmodule

>>> hw/rtl/sidm_cell.sv
// ----------------------------------------------------------------------------
// sidm_cell
// One restoring-division step: shifts in a dividend bit, trial subtract,
// shifts in one quotient bit. Registered; one cell per quotient bit.
// ----------------------------------------------------------------------------
module sidm_cell #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  sidm_pkg::sidm_ctl_t   ctl_i,
  input  logic [DATA_WIDTH-1:0] ay_i,
  input  logic [DATA_WIDTH-1:0] uy_i,
  input  logic [DATA_WIDTH-1:0] rem_i,
  input  logic [DATA_WIDTH-1:0] qd_i,
  output sidm_pkg::sidm_ctl_t   ctl_o,
  output logic [DATA_WIDTH-1:0] ay_o,
  output logic [DATA_WIDTH-1:0] uy_o,
  output logic [DATA_WIDTH-1:0] rem_o,
  output logic [DATA_WIDTH-1:0] qd_o
);
  import sidm_pkg::*;

  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;
  logic [DATA_WIDTH-1:0] rem_nxt, qd_nxt;
  sidm_ctl_t             ctl_r;
  logic [DATA_WIDTH-1:0] ay_r, uy_r, rem_r, qd_r;

  // qd holds remaining dividend bits at the top, quotient bits fill the bottom
  always_comb begin
    shifted = {rem_i, qd_i[DATA_WIDTH-1]};
    diff    = shifted - {1'b0, ay_i};
    ge      = ~diff[DATA_WIDTH];
    rem_nxt = ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
    qd_nxt  = {qd_i[DATA_WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ay_r  <= ay_i;
      uy_r  <= uy_i;
      rem_r <= rem_nxt;
      qd_r  <= qd_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign ay_o  = ay_r;
  assign uy_o  = uy_r;
  assign rem_o = rem_r;
  assign qd_o  = qd_r;

endmodule

>>> hw/rtl/sidm_back.sv
// ----------------------------------------------------------------------------
// sidm_back
// Output stages: sign restore of quotient and remainder, then modulo fixup,
// operation select and the output register.
// ----------------------------------------------------------------------------
module sidm_back #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  sidm_pkg::sidm_ctl_t   ctl_i,
  input  logic [DATA_WIDTH-1:0] uy_i,
  input  logic [DATA_WIDTH-1:0] rem_i,
  input  logic [DATA_WIDTH-1:0] q_i,
  output logic                  out_valid,
  output sidm_pkg::sidm_out_t   out_data
);
  import sidm_pkg::*;

  sidm_ctl_t             ctl_r;
  logic [DATA_WIDTH-1:0] uq_nxt, ur_nxt;
  logic [DATA_WIDTH-1:0] uq_r, ur_r, uy_r;
  logic                  rnz_r;
  logic [DATA_WIDTH-1:0] res;
  logic                  out_valid_r;
  sidm_out_t             out_data_nxt, out_data_r;

  always_comb begin
    uq_nxt = (ctl_i.negx ^ ctl_i.negy) ? (~q_i + 1'b1) : q_i;
    ur_nxt = ctl_i.negx ? (~rem_i + 1'b1) : rem_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uq_r  <= uq_nxt;
      ur_r  <= ur_nxt;
      uy_r  <= uy_i;
      rnz_r <= (rem_i != '0);
    end
  end

  always_comb begin
    case (ctl_r.op)
      OP_QUOT: res = uq_r;
      OP_REM:  res = ur_r;
      OP_MOD:  res = ((ctl_r.negx != ctl_r.negy) && rnz_r) ? (ur_r + uy_r) : ur_r;
      default: res = '0;
    endcase
    if (ctl_r.dz) begin
      res = '0;
    end
    out_data_nxt.result         = 64'($signed(res));
    out_data_nxt.divide_by_zero = ctl_r.dz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/signed_integer_divide_modulo.sv
// ----------------------------------------------------------------------------
// signed_integer_divide_modulo
// Pipelined signed divider: truncating quotient, remainder, floored modulo.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_data carries op, dividend, divisor.
//   Result channel out_valid/out_ready/out_data carries result and
//   divide_by_zero. Operands use their low DATA_WIDTH bits, sign-extended;
//   the result is sign-extended from bit DATA_WIDTH-1.
//   One input stage, one restoring cell per quotient bit, two output
//   stages. Throughput is one word per cycle unless the output stalls;
//   the chain of cells is a plain pipeline, every word moving one cell a cycle.
//   When the receiver stalls with a result pending, the whole chain holds
//   and in_ready drops; in_ready is high whenever the output register is
//   empty or being taken in the same cycle.
//   Reset clears all valid bits; words in flight are dropped.
//   A zero divisor returns result 0 with divide_by_zero set. The most
//   negative value over -1 gives the most negative value as quotient and
//   0 as remainder and modulo. Op code 3 returns 0.
// ----------------------------------------------------------------------------
module signed_integer_divide_modulo #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sidm_pkg::sidm_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sidm_pkg::sidm_out_t  out_data
);
  import sidm_pkg::*;

  logic                  advance;
  sidm_ctl_t             ctl_c [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] ay_c  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] uy_c  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] rem_c [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] qd_c  [0:DATA_WIDTH];

  assign advance  = ~out_valid | out_ready;
  assign in_ready = advance;

  sidm_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .in_valid (in_valid),
    .in_data  (in_data),
    .ctl_o    (ctl_c[0]),
    .ay_o     (ay_c[0]),
    .uy_o     (uy_c[0]),
    .rem_o    (rem_c[0]),
    .qd_o     (qd_c[0])
  );

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
    sidm_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (advance),
      .ctl_i (ctl_c[k]),
      .ay_i  (ay_c[k]),
      .uy_i  (uy_c[k]),
      .rem_i (rem_c[k]),
      .qd_i  (qd_c[k]),
      .ctl_o (ctl_c[k+1]),
      .ay_o  (ay_c[k+1]),
      .uy_o  (uy_c[k+1]),
      .rem_o (rem_c[k+1]),
      .qd_o  (qd_c[k+1])
    );
  end

  // divisor magnitude is no longer needed past the last cell
  sidm_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .ctl_i     (ctl_c[DATA_WIDTH]),
    .uy_i      (uy_c[DATA_WIDTH]),
    .rem_i     (rem_c[DATA_WIDTH]),
    .q_i       (qd_c[DATA_WIDTH]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_by_zero |-> out_data.result == '0)
    else $error("divide by zero with nonzero result");

  a_chain_moves: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> ctl_c[DATA_WIDTH].valid == $past(ctl_c[DATA_WIDTH-1].valid))
    else $error("cell chain lost or duplicated a word");

  a_chain_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(ctl_c[0].valid) && $stable(ctl_c[DATA_WIDTH].valid))
    else $error("cell chain moved during output stall");

  a_front_load: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> ctl_c[0].valid == $past(in_valid))
    else $error("input stage valid does not follow accepted word");
`endif

endmodule
